### hdl/tsd_pkg.sv
// Shared types and constants for the tilt shake detector.
// No dependencies.
package tsd_pkg;

    localparam int RING_DEPTH_DEF = 16;

    localparam logic [4:0]  TICK_COUNT_RESET = 5'd4;
    localparam logic [15:0] WINDOW_RESET     = 16'd500;
    localparam logic [15:0] MIN_GAP_RESET    = 16'd50;

    localparam logic [1:0] CFG_TICK_COUNT = 2'd0;
    localparam logic [1:0] CFG_WINDOW_MS  = 2'd1;
    localparam logic [1:0] CFG_MIN_GAP_MS = 2'd2;

    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_POLL = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [31:0] time_ms;
    } t_in_item;

    typedef struct packed {
        logic tick_taken;
        logic shake;
    } t_out_item;

    typedef struct packed {
        logic [4:0]  tick_count;
        logic [15:0] window_ms;
        logic [15:0] min_gap_ms;
    } t_cfg;

    typedef struct packed {
        logic        write;
        logic        reseed;
        logic [31:0] stamp;
    } t_ring_cmd;

endpackage

### hdl/tsd_cfg.sv
// Configuration registers of the tilt shake detector.
// Depends on tsd_pkg.
module tsd_cfg
    import tsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tick_count <= TICK_COUNT_RESET;
            r_cfg.window_ms  <= WINDOW_RESET;
            r_cfg.min_gap_ms <= MIN_GAP_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_TICK_COUNT: r_cfg.tick_count <= i_cfg_data[4:0];
                CFG_WINDOW_MS:  r_cfg.window_ms  <= i_cfg_data;
                CFG_MIN_GAP_MS: r_cfg.min_gap_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/tsd_ring.sv
// Timestamp ring: stamp registers, head pointer, parallel reseed.
// Depends on tsd_pkg.
module tsd_ring
    import tsd_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [4:0]  i_tick_count,
    input  logic [15:0] i_window_ms,
    input  t_ring_cmd   i_cmd,
    output logic [31:0] o_newest,
    output logic [31:0] o_oldest
);

    localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int NW = ($clog2(RING_DEPTH + 1) > 6) ? $clog2(RING_DEPTH + 1) : 6;

    logic [31:0]   r_stamp [RING_DEPTH];
    logic [IW-1:0] r_head;
    logic [31:0]   r_newest;

    logic [NW-1:0] count;
    logic [NW-1:0] eff_count;
    logic [NW-1:0] head_inc;
    logic [IW-1:0] next_pos;

    always_comb begin
        count = NW'(i_tick_count);
        if (count < NW'(2)) begin
            eff_count = NW'(2);
        end else if (count > NW'(RING_DEPTH)) begin
            eff_count = NW'(RING_DEPTH);
        end else begin
            eff_count = count;
        end
        head_inc = NW'(r_head) + NW'(1);
        next_pos = (head_inc >= eff_count) ? '0 : head_inc[IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < RING_DEPTH; i++) begin
                r_stamp[i] <= 32'(i) * 32'(WINDOW_RESET);
            end
            r_head   <= '0;
            r_newest <= '0;
        end else if (i_cmd.reseed) begin
            for (int i = 0; i < RING_DEPTH; i++) begin
                r_stamp[i] <= 32'(i) * 32'(i_window_ms);
            end
            r_head   <= '0;
            r_newest <= '0;
        end else if (i_cmd.write) begin
            r_stamp[next_pos] <= i_cmd.stamp;
            r_head            <= next_pos;
            r_newest          <= i_cmd.stamp;
        end
    end

    // r_newest mirrors the entry at the head
    assign o_newest = r_newest;
    assign o_oldest = r_stamp[next_pos];

endmodule

### hdl/tilt_shake_detector_core.sv
// Tilt shake detector: debounces tilt-switch edges into a timestamp ring
// and reports a shake when a poll finds all recent ticks inside the window.
// Depends on tsd_pkg, tsd_cfg, tsd_ring.
//
// One item per clock, sustained unless the output stalls. Each item passes
// an input register, is evaluated combinationally against the ring and
// lands in a result register. The rate is set by the ring being plain
// registers: the newest stamp is held in its own register, the oldest is
// one mux read, and a reseed rewrites every entry at once. There is no
// clearing pass after reset. The user must write configuration only while
// no item is in flight; this is not enforced. Writes never reseed the ring.
module tilt_shake_detector_core
    import tsd_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg      cfg;
    t_ring_cmd ring_cmd;
    logic [31:0] newest;
    logic [31:0] oldest;

    logic      r_s1_valid;
    t_in_item  r_s1_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item n_out_item;

    logic        out_free;
    logic        fire;
    logic [31:0] gap;
    logic [31:0] span;

    tsd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tsd_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick_count (cfg.tick_count),
        .i_window_ms  (cfg.window_ms),
        .i_cmd        (ring_cmd),
        .o_newest     (newest),
        .o_oldest     (oldest)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !out_free;
    assign fire       = r_s1_valid && out_free;

    always_comb begin
        gap  = r_s1_item.time_ms - newest;
        span = newest - oldest;
        n_out_item.tick_taken = (r_s1_item.kind == KIND_EDGE) &&
                                (gap > {16'd0, cfg.min_gap_ms});
        n_out_item.shake      = (r_s1_item.kind == KIND_POLL) &&
                                (span < {16'd0, cfg.window_ms});
        ring_cmd.write  = fire && n_out_item.tick_taken;
        ring_cmd.reseed = fire && n_out_item.shake;
        ring_cmd.stamp  = r_s1_item.time_ms;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

### tb/tb_tilt_shake_detector_core.sv
// Self-checking testbench for tilt_shake_detector_core: a queue-fed driver, a monitor
// and a cycle-free predictor of the timestamp ring check every result item.
// Depends on tsd_pkg and the tilt_shake_detector_core RTL.
`timescale 1ns / 100ps

module tb_tilt_shake_detector_core;
    import tsd_pkg::*;

    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam int N_SEG = 6;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_item;
    logic        i_cfg_wr_en = 1'b0;
    logic [1:0]  i_cfg_index = CFG_TICK_COUNT;
    logic [15:0] i_cfg_data = '0;

    tilt_shake_detector_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [31:0] stamp_mdl [RING_DEPTH_DEF];
    int          head_mdl;
    logic [4:0]  tick_mdl;
    logic [15:0] window_mdl;
    logic [15:0] gap_mdl;

    t_in_item  pending_in_q [$];
    t_out_item predicted_detect_q [$];

    int unsigned items_pushed = 0;
    int unsigned items_accepted = 0;
    int unsigned results_seen = 0;
    int unsigned ticks_seen = 0;
    int unsigned shakes_seen = 0;
    int unsigned errors = 0;
    int          send_idle = 0;
    int          recv_idle = 0;
    logic        long_hold = 1'b0;
    logic [31:0] cur_ms = '0;

    logic [4:0]  tick_plan   [N_SEG] = '{5'd16, 5'd2, 5'd0, 5'd31, 5'd1, 5'd7};
    logic [15:0] window_plan [N_SEG] = '{16'd65535, 16'd300, 16'd0, 16'd20000, 16'd1000,
                                         16'd5000};
    logic [15:0] gap_plan    [N_SEG] = '{16'd0, 16'd10, 16'd65535, 16'd100, 16'd1, 16'd200};

    function automatic void reseed_ring();
        for (int i = 0; i < RING_DEPTH_DEF; i++)
            stamp_mdl[i] = 32'(i) * {16'h0, window_mdl};
        head_mdl = 0;
    endfunction

    function automatic int eff_ticks();
        if (tick_mdl < 5'd2)
            return 2;
        if (int'(tick_mdl) > RING_DEPTH_DEF)
            return RING_DEPTH_DEF;
        return int'(tick_mdl);
    endfunction

    function automatic t_out_item detect_step(t_in_item it);
        t_out_item   r;
        int          slot;
        logic [31:0] diff;
        r = '0;
        slot = head_mdl + 1;
        if (slot >= eff_ticks())
            slot = 0;
        if (it.kind == KIND_EDGE) begin
            diff = it.time_ms - stamp_mdl[head_mdl];
            if (diff > {16'h0, gap_mdl}) begin
                head_mdl = slot;
                stamp_mdl[slot] = it.time_ms;
                r.tick_taken = 1'b1;
            end
        end else begin
            diff = stamp_mdl[head_mdl] - stamp_mdl[slot];
            if (diff < {16'h0, window_mdl}) begin
                reseed_ring();
                r.shake = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic want, input logic got);
        $display("MISMATCH at result %0d: %s expected %0b got %0b", results_seen, what,
                 want, got);
        errors++;
    endtask

    task automatic push_item(input logic kind, input logic [31:0] t);
        t_in_item it;
        it.kind = kind;
        it.time_ms = t;
        pending_in_q.push_back(it);
        items_pushed++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_TICK_COUNT: tick_mdl = val[4:0];
            CFG_WINDOW_MS:  window_mdl = val;
            CFG_MIN_GAP_MS: gap_mdl = val;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (results_seen != items_pushed)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // mostly complete tick bursts followed by a poll; the rest is chatter and noise
    task automatic gen_random(input int n);
        int unsigned target;
        int          r;
        int          k;
        int          cap;
        target = items_pushed + n;
        while (items_pushed < target) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                k = eff_ticks() + $urandom_range(0, 2) - 1;
                cap = int'(window_mdl) / eff_ticks();
                cur_ms += {16'h0, gap_mdl} + 1 + $urandom_range(0, 100000);
                push_item(KIND_EDGE, cur_ms);
                for (int j = 1; j < k; j++) begin
                    if ($urandom_range(0, 4) == 0)
                        push_item(KIND_EDGE, cur_ms + $urandom_range(0, gap_mdl));
                    cur_ms += {16'h0, gap_mdl} + 1 + $urandom_range(0, cap);
                    push_item(KIND_EDGE, cur_ms);
                end
                push_item(KIND_POLL, $urandom);
            end else if (r < 85) begin
                repeat ($urandom_range(2, 6)) begin
                    cur_ms += $urandom_range(0, int'(gap_mdl) + 2);
                    push_item(KIND_EDGE, cur_ms);
                end
            end else if (r < 93) begin
                push_item(KIND_EDGE, $urandom);
            end else begin
                push_item(KIND_POLL, $urandom);
            end
        end
    endtask

    always @(posedge i_clk) begin : drv
        logic     nxt_valid;
        t_in_item nxt_item;
        nxt_valid = i_in_valid;
        nxt_item = i_in_item;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predicted_detect_q.push_back(detect_step(i_in_item));
                items_accepted++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && pending_in_q.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle) begin
                nxt_item = pending_in_q.pop_front();
                nxt_valid = 1'b1;
            end
        end
        i_in_valid <= nxt_valid;
        i_in_item  <= nxt_item;
    end

    always @(posedge i_clk) begin : mon
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (predicted_detect_q.size() == 0) begin
                report_mismatch("result with nothing pending, valid", 1'b0, 1'b1);
            end else begin
                want = predicted_detect_q.pop_front();
                if (o_out_item.tick_taken !== want.tick_taken)
                    report_mismatch("tick_taken", want.tick_taken, o_out_item.tick_taken);
                if (o_out_item.shake !== want.shake)
                    report_mismatch("shake", want.shake, o_out_item.shake);
                ticks_seen += want.tick_taken;
                shakes_seen += want.shake;
            end
        end
        i_out_stall <= long_hold || ($urandom_range(0, 99) < recv_idle);
    end

    // long receiver hold-off so the pipeline backs up into the input
    initial begin : hold_off
        while (items_accepted < 260)
            @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (400) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    initial begin : timeout
        #5_000_000;
        $display("tilt_shake_detector_core test failed");
        $finish;
    end

    initial begin : main
        tick_mdl = TICK_COUNT_RESET;
        window_mdl = WINDOW_RESET;
        gap_mdl = MIN_GAP_RESET;
        reseed_ring();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle = 31;
        recv_idle = 86;

        // directed: reset seeds, wrap, exact gap, shake and reseed
        push_item(KIND_POLL, 32'h0);
        push_item(KIND_EDGE, 32'hFFFF_FFFF);
        push_item(KIND_EDGE, 32'h0);
        push_item(KIND_EDGE, 32'd50);
        push_item(KIND_EDGE, 32'd100);
        push_item(KIND_EDGE, 32'd101);
        push_item(KIND_EDGE, 32'd300);
        push_item(KIND_POLL, 32'h0);
        push_item(KIND_POLL, 32'hFFFF_FFFF);
        push_item(KIND_EDGE, 32'd51);
        push_item(KIND_EDGE, 32'd200);
        push_item(KIND_EDGE, 32'd300);
        push_item(KIND_EDGE, 32'd400);
        push_item(KIND_POLL, 32'h5555_5555);
        push_item(KIND_EDGE, 32'h8000_0000);
        push_item(KIND_EDGE, 32'h7FFF_FFFF);
        push_item(KIND_POLL, 32'hFFFF_FFFF);
        push_item(KIND_EDGE, 32'hAAAA_AAAA);
        push_item(KIND_EDGE, 32'h5555_5555);
        push_item(KIND_POLL, 32'hAAAA_AAAA);
        wait_drained();

        for (int s = 0; s < N_SEG; s++) begin
            if (s < 2) begin
                send_idle = 31;
                recv_idle = 86;
            end else if (s < 4) begin
                send_idle = 86;
                recv_idle = 31;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            write_reg(CFG_TICK_COUNT, {11'($urandom), tick_plan[s]});
            write_reg(CFG_WINDOW_MS, window_plan[s]);
            write_reg(CFG_MIN_GAP_MS, gap_plan[s]);
            if (s == 1)
                write_reg(CFG_SPARE, 16'($urandom));
            cur_ms = $urandom;
            gen_random(180);
            if (s == 0) begin
                // full ring then shake, then leave the head high for the smaller count
                repeat (RING_DEPTH_DEF) begin
                    cur_ms += 1;
                    push_item(KIND_EDGE, cur_ms);
                end
                push_item(KIND_POLL, $urandom);
                repeat (10) begin
                    cur_ms += 1;
                    push_item(KIND_EDGE, cur_ms);
                end
            end
            wait_drained();
        end

        if (predicted_detect_q.size() != 0)
            report_mismatch("leftover predictions, none", 1'b0, 1'b1);
        $display("Covered %0d items under %0d register settings with varied idling;",
                 items_accepted, N_SEG + 1);
        $display("%0d ticks recorded, %0d shakes reported, %0d mismatches.",
                 ticks_seen, shakes_seen, errors);
        if (errors == 0)
            $display("tilt_shake_detector_core test passed");
        else
            $display("tilt_shake_detector_core test failed");
        $finish;
    end

endmodule

### sim.f
hdl/tsd_pkg.sv
hdl/tsd_cfg.sv
hdl/tsd_ring.sv
hdl/tilt_shake_detector_core.sv
tb/tb_tilt_shake_detector_core.sv
